>>> rtl/core/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared constants and codes of the first-fit free-list allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffa_pkg;

	localparam int FREE_ENTRIES_DEF = 32;
	localparam int ADDR_BITS_DEF    = 32;

	localparam logic [32:0] INIT_CAP_RESET = 33'd1024;

	typedef logic [2:0] status_t;

	localparam status_t ST_OK    = 3'd0;
	localparam status_t ST_ZERO  = 3'd1;
	localparam status_t ST_ALIGN = 3'd2;
	localparam status_t ST_OVF   = 3'd3;
	localparam status_t ST_FULL  = 3'd4;

endpackage

`default_nettype wire

>>> rtl/core/ffa_ram.sv
// ----------------------------------------------------------------------------
// ffa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> rtl/core/first_fit_free_list_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator
// First-fit allocator over a free list with growth and coalescing.
// ----------------------------------------------------------------------------
// One request is in work at a time; the next request is taken while the
// previous result still waits in the output register. The free list lives in
// a RAM with one read and one write port, so cost follows the entry count:
// an allocate scans the entries, moves up the entries behind the taken one
// and may grow the capacity. A free copies the list into a scratch RAM, sorts
// it by insertion, merges it and copies it back. Zero-size requests and
// requests that fail the input checks go straight to the done state. There
// is no clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_free_list_allocator #(
	parameter int FREE_ENTRIES = ffa_pkg::FREE_ENTRIES_DEF,
	parameter int ADDR_BITS    = ffa_pkg::ADDR_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [32:0] cfg_wr_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        mode,
	input  wire logic [31:0] block_size,
	input  wire logic [31:0] align_bytes,
	input  wire logic [31:0] region_offset,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       status,
	output logic [31:0]      granted_offset,
	output logic [31:0]      granted_size,
	output logic [32:0]      capacity,
	output logic             grew
);

	import ffa_pkg::*;

	localparam int OW  = ADDR_BITS;
	localparam int SW  = ADDR_BITS + 1;
	localparam int EW  = OW + SW;
	localparam int XW  = ((ADDR_BITS > 32) ? ADDR_BITS : 32) + 2;
	localparam int IW  = $clog2(FREE_ENTRIES);
	localparam int SIW = $clog2(FREE_ENTRIES + 1);
	localparam int CW  = $clog2(FREE_ENTRIES + 1);
	localparam int NW  = $clog2(FREE_ENTRIES + 2);

	localparam logic [XW-1:0] LIMIT = XW'(1) << ADDR_BITS;
	localparam logic [XW-1:0] RST_CAP =
		(XW'(INIT_CAP_RESET) > LIMIT) ? LIMIT : XW'(INIT_CAP_RESET);
	localparam logic [NW:0] FREE_N = (NW+1)'(FREE_ENTRIES);

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_A_RD   = 5'd1;
	localparam logic [4:0] S_A_EV1  = 5'd2;
	localparam logic [4:0] S_A_EV2  = 5'd3;
	localparam logic [4:0] S_A_EV3  = 5'd4;
	localparam logic [4:0] S_A_SHRD = 5'd5;
	localparam logic [4:0] S_A_SHWR = 5'd6;
	localparam logic [4:0] S_PUSH1  = 5'd7;
	localparam logic [4:0] S_PUSH2  = 5'd8;
	localparam logic [4:0] S_G_AL   = 5'd9;
	localparam logic [4:0] S_G_NEED = 5'd10;
	localparam logic [4:0] S_G_CHK0 = 5'd11;
	localparam logic [4:0] S_G_LOOP = 5'd12;
	localparam logic [4:0] S_G_CHK  = 5'd13;
	localparam logic [4:0] S_F_CRD  = 5'd14;
	localparam logic [4:0] S_F_CWR  = 5'd15;
	localparam logic [4:0] S_F_NEW  = 5'd16;
	localparam logic [4:0] S_F_KRD  = 5'd17;
	localparam logic [4:0] S_F_KEY  = 5'd18;
	localparam logic [4:0] S_F_JCHK = 5'd19;
	localparam logic [4:0] S_F_JCMP = 5'd20;
	localparam logic [4:0] S_F_KWR  = 5'd21;
	localparam logic [4:0] S_F_M0   = 5'd22;
	localparam logic [4:0] S_F_M0D  = 5'd23;
	localparam logic [4:0] S_F_MRD  = 5'd24;
	localparam logic [4:0] S_F_MCMP = 5'd25;
	localparam logic [4:0] S_F_MLST = 5'd26;
	localparam logic [4:0] S_F_BRD  = 5'd27;
	localparam logic [4:0] S_F_BWR  = 5'd28;
	localparam logic [4:0] S_DONE   = 5'd29;

	logic [4:0]    state_q;
	logic [CW-1:0] cnt_q;
	logic [SW-1:0] cap_q;
	logic          ovr_q;
	logic [SW-1:0] ovr_sz_q;
	logic          use_ovr_s1;

	logic          mode_q;
	logic [XW-1:0] size_q, am1_q;
	logic [OW-1:0] roff_q;
	logic [XW-1:0] off_q, end_q, al_q, alsz_q;
	logic [XW-1:0] p1_off_q, p1_sz_q, p2_off_q, p2_sz_q;
	logic [XW-1:0] alo_q, need_q, gcap_q;
	logic [EW-1:0] key_q;
	logic [OW-1:0] cur_off_q;
	logic [SW-1:0] cur_sz_q;
	logic [XW-1:0] cur_end_q;
	logic [NW-1:0] i_q, j_q, m_q, n_q;
	status_t       st_q;
	logic [XW-1:0] gofs_q;
	logic          grew_q;

	logic          lw_en, sw_en;
	logic [IW-1:0] l_raddr, lw_addr;
	logic [SIW-1:0] s_raddr, sw_addr;
	logic [EW-1:0] lw_data, sw_data, l_ram_rd, list_rd, s_rd;

	logic          in_acc, out_load;
	logic [XW-1:0] in_size_x, cfg_x, cfg_cap;
	logic          in_al_bad, in_free_ovf;
	logic [OW-1:0] l_off, s_off;
	logic [SW-1:0] l_sz, s_sz;
	logic [XW-1:0] s_end;
	logic          fit, a_full, g_full, merge, key_gt;
	logic [NW-1:0] i1, jm1;
	logic [XW-1:0] dbl, dmin;

	ffa_ram #(.WIDTH(EW), .DEPTH(FREE_ENTRIES)) u_list (
		.clk   (clk),
		.we    (lw_en),
		.waddr (lw_addr),
		.wdata (lw_data),
		.raddr (l_raddr),
		.rdata (l_ram_rd)
	);

	ffa_ram #(.WIDTH(EW), .DEPTH(FREE_ENTRIES + 1)) u_scratch (
		.clk   (clk),
		.we    (sw_en),
		.waddr (sw_addr),
		.wdata (sw_data),
		.raddr (s_raddr),
		.rdata (s_rd)
	);

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_load = (state_q == S_DONE) && (!out_valid || !out_stall);

	assign in_size_x   = XW'(block_size);
	assign in_al_bad   = (align_bytes == 32'd0) ||
		((align_bytes & (align_bytes - 32'd1)) != 32'd0);
	assign in_free_ovf = (XW'(region_offset) + in_size_x) > LIMIT;
	assign cfg_x       = XW'(cfg_wr_data);
	assign cfg_cap     = (cfg_x > LIMIT) ? LIMIT : cfg_x;

	assign list_rd = use_ovr_s1 ? {{OW{1'b0}}, ovr_sz_q} : l_ram_rd;
	assign l_off   = list_rd[EW-1:SW];
	assign l_sz    = list_rd[SW-1:0];
	assign s_off   = s_rd[EW-1:SW];
	assign s_sz    = s_rd[SW-1:0];
	assign s_end   = XW'(s_off) + XW'(s_sz);

	assign fit    = end_q >= alsz_q;
	assign a_full = ((NW+1)'(cnt_q) + (NW+1)'(al_q != off_q) + (NW+1)'(end_q != alsz_q))
		> (FREE_N + (NW+1)'(1));
	assign g_full = ((NW+1)'(cnt_q) + (NW+1)'(alo_q != XW'(cap_q))
		+ (NW+1)'(gcap_q != need_q)) > FREE_N;
	assign merge  = cur_end_q == XW'(s_off);
	assign key_gt = s_off > key_q[EW-1:SW];
	assign i1     = i_q + NW'(1);
	assign jm1    = j_q - NW'(1);
	assign dbl    = gcap_q << 1;
	assign dmin   = (dbl > LIMIT) ? LIMIT : dbl;

	always_comb begin
		lw_en   = 1'b0;
		lw_addr = i_q[IW-1:0];
		lw_data = s_rd;
		l_raddr = i_q[IW-1:0];
		sw_en   = 1'b0;
		sw_addr = i_q[SIW-1:0];
		sw_data = list_rd;
		s_raddr = i_q[SIW-1:0];
		case (state_q)
			S_A_SHRD: begin
				l_raddr = i1[IW-1:0];
			end
			S_A_SHWR: begin
				lw_en   = 1'b1;
				lw_data = list_rd;
			end
			S_PUSH1: begin
				lw_en   = p1_sz_q != '0;
				lw_addr = cnt_q[IW-1:0];
				lw_data = {OW'(p1_off_q), SW'(p1_sz_q)};
			end
			S_PUSH2: begin
				lw_en   = p2_sz_q != '0;
				lw_addr = cnt_q[IW-1:0];
				lw_data = {OW'(p2_off_q), SW'(p2_sz_q)};
			end
			S_F_CWR: begin
				sw_en = 1'b1;
			end
			S_F_NEW: begin
				sw_en   = 1'b1;
				sw_addr = SIW'(cnt_q);
				sw_data = {roff_q, SW'(size_q)};
			end
			S_F_JCHK: begin
				s_raddr = jm1[SIW-1:0];
			end
			S_F_JCMP: begin
				sw_en   = key_gt;
				sw_addr = j_q[SIW-1:0];
				sw_data = s_rd;
			end
			S_F_KWR: begin
				sw_en   = 1'b1;
				sw_addr = j_q[SIW-1:0];
				sw_data = key_q;
			end
			S_F_M0: begin
				s_raddr = '0;
			end
			S_F_MCMP: begin
				sw_en   = !merge;
				sw_addr = m_q[SIW-1:0];
				sw_data = {cur_off_q, cur_sz_q};
			end
			S_F_MLST: begin
				sw_en   = 1'b1;
				sw_addr = m_q[SIW-1:0];
				sw_data = {cur_off_q, cur_sz_q};
			end
			S_F_BWR: begin
				lw_en = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= CW'(RST_CAP != '0);
			cap_q      <= SW'(RST_CAP);
			ovr_q      <= 1'b1;
			ovr_sz_q   <= SW'(RST_CAP);
			use_ovr_s1 <= 1'b0;
			out_valid  <= 1'b0;
		end else begin
			use_ovr_s1 <= ovr_q && (l_raddr == '0);
			if (lw_en && lw_addr == '0) begin
				ovr_q <= 1'b0;
			end
			if (cfg_wr_en) begin
				cap_q    <= SW'(cfg_cap);
				cnt_q    <= CW'(cfg_cap != '0);
				ovr_q    <= 1'b1;
				ovr_sz_q <= SW'(cfg_cap);
			end
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (block_size == 32'd0) begin
							state_q <= S_DONE;
						end else if (!mode) begin
							if (in_al_bad) begin
								state_q <= S_DONE;
							end else if (cnt_q == '0) begin
								state_q <= S_G_AL;
							end else begin
								state_q <= S_A_RD;
							end
						end else if (in_free_ovf) begin
							state_q <= S_DONE;
						end else if (cnt_q == '0) begin
							state_q <= S_F_NEW;
						end else begin
							state_q <= S_F_CRD;
						end
					end
				end
				S_A_RD:  state_q <= S_A_EV1;
				S_A_EV1: state_q <= S_A_EV2;
				S_A_EV2: state_q <= S_A_EV3;
				S_A_EV3: begin
					if (fit) begin
						if (a_full) begin
							state_q <= S_DONE;
						end else begin
							cnt_q <= cnt_q - CW'(1);
							if (i1 < NW'(cnt_q)) begin
								state_q <= S_A_SHRD;
							end else begin
								state_q <= S_PUSH1;
							end
						end
					end else if (i1 == NW'(cnt_q)) begin
						state_q <= S_G_AL;
					end else begin
						state_q <= S_A_RD;
					end
				end
				S_A_SHRD: state_q <= S_A_SHWR;
				S_A_SHWR: begin
					if (i_q + NW'(2) <= NW'(cnt_q)) begin
						state_q <= S_A_SHRD;
					end else begin
						state_q <= S_PUSH1;
					end
				end
				S_PUSH1: begin
					if (p1_sz_q != '0) begin
						cnt_q <= cnt_q + CW'(1);
					end
					state_q <= S_PUSH2;
				end
				S_PUSH2: begin
					if (p2_sz_q != '0) begin
						cnt_q <= cnt_q + CW'(1);
					end
					state_q <= S_DONE;
				end
				S_G_AL:   state_q <= S_G_NEED;
				S_G_NEED: state_q <= S_G_CHK0;
				S_G_CHK0: begin
					if (need_q > LIMIT) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_G_LOOP;
					end
				end
				S_G_LOOP: begin
					if (!(need_q > gcap_q)) begin
						state_q <= S_G_CHK;
					end
				end
				S_G_CHK: begin
					if (g_full) begin
						state_q <= S_DONE;
					end else begin
						cap_q   <= SW'(gcap_q);
						state_q <= S_PUSH1;
					end
				end
				S_F_CRD: state_q <= S_F_CWR;
				S_F_CWR: begin
					if (i1 == NW'(cnt_q)) begin
						state_q <= S_F_NEW;
					end else begin
						state_q <= S_F_CRD;
					end
				end
				S_F_NEW: begin
					if (cnt_q == '0) begin
						state_q <= S_F_M0;
					end else begin
						state_q <= S_F_KRD;
					end
				end
				S_F_KRD: state_q <= S_F_KEY;
				S_F_KEY: state_q <= S_F_JCHK;
				S_F_JCHK: begin
					if (j_q == '0) begin
						state_q <= S_F_KWR;
					end else begin
						state_q <= S_F_JCMP;
					end
				end
				S_F_JCMP: begin
					if (key_gt) begin
						state_q <= S_F_JCHK;
					end else begin
						state_q <= S_F_KWR;
					end
				end
				S_F_KWR: begin
					if (i1 == n_q) begin
						state_q <= S_F_M0;
					end else begin
						state_q <= S_F_KRD;
					end
				end
				S_F_M0:  state_q <= S_F_M0D;
				S_F_M0D: state_q <= S_F_MRD;
				S_F_MRD: begin
					if (i_q == n_q) begin
						state_q <= S_F_MLST;
					end else begin
						state_q <= S_F_MCMP;
					end
				end
				S_F_MCMP: state_q <= S_F_MRD;
				S_F_MLST: begin
					if ((NW+1)'(m_q) + (NW+1)'(1) > FREE_N) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_F_BRD;
					end
				end
				S_F_BRD: state_q <= S_F_BWR;
				S_F_BWR: begin
					if (i1 == m_q) begin
						cnt_q   <= CW'(m_q);
						state_q <= S_DONE;
					end else begin
						state_q <= S_F_BRD;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status         <= st_q;
			granted_offset <= 32'(gofs_q);
			granted_size   <= (st_q == ST_OK && !mode_q) ? 32'(size_q) : 32'd0;
			capacity       <= 33'(cap_q);
			grew           <= grew_q;
		end
		case (state_q)
			S_IDLE: begin
				mode_q <= mode;
				size_q <= in_size_x;
				am1_q  <= XW'(align_bytes) - XW'(1);
				roff_q <= OW'(region_offset);
				gofs_q <= '0;
				grew_q <= 1'b0;
				i_q    <= '0;
				if (block_size == 32'd0) begin
					st_q <= mode ? ST_OK : ST_ZERO;
				end else if (!mode && in_al_bad) begin
					st_q <= ST_ALIGN;
				end else if (mode && in_free_ovf) begin
					st_q <= ST_OVF;
				end else begin
					st_q <= ST_OK;
				end
			end
			S_A_EV1: begin
				off_q <= XW'(l_off);
				end_q <= XW'(l_off) + XW'(l_sz);
				al_q  <= (XW'(l_off) + am1_q) & ~am1_q;
			end
			S_A_EV2: begin
				alsz_q <= al_q + size_q;
			end
			S_A_EV3: begin
				if (fit) begin
					if (a_full) begin
						st_q <= ST_FULL;
					end else begin
						p1_off_q <= off_q;
						p1_sz_q  <= al_q - off_q;
						p2_off_q <= alsz_q;
						p2_sz_q  <= end_q - alsz_q;
						gofs_q   <= al_q;
					end
				end else begin
					i_q <= i1;
				end
			end
			S_A_SHWR: i_q <= i1;
			S_G_AL: begin
				alo_q  <= (XW'(cap_q) + am1_q) & ~am1_q;
				gcap_q <= XW'(cap_q);
			end
			S_G_NEED: need_q <= alo_q + size_q;
			S_G_CHK0: begin
				if (need_q > LIMIT) begin
					st_q <= ST_OVF;
				end
			end
			S_G_LOOP: begin
				if (need_q > gcap_q) begin
					gcap_q <= (dmin > size_q) ? dmin : size_q;
				end
			end
			S_G_CHK: begin
				if (g_full) begin
					st_q <= ST_FULL;
				end else begin
					p1_off_q <= XW'(cap_q);
					p1_sz_q  <= alo_q - XW'(cap_q);
					p2_off_q <= need_q;
					p2_sz_q  <= gcap_q - need_q;
					gofs_q   <= alo_q;
					grew_q   <= 1'b1;
				end
			end
			S_F_CWR: i_q <= i1;
			S_F_NEW: begin
				i_q <= NW'(1);
				n_q <= NW'(cnt_q) + NW'(1);
			end
			S_F_KEY: begin
				key_q <= s_rd;
				j_q   <= i_q;
			end
			S_F_JCMP: begin
				if (key_gt) begin
					j_q <= jm1;
				end
			end
			S_F_KWR: i_q <= i1;
			S_F_M0D: begin
				cur_off_q <= s_off;
				cur_sz_q  <= s_sz;
				cur_end_q <= s_end;
				i_q       <= NW'(1);
				m_q       <= '0;
			end
			S_F_MCMP: begin
				if (merge) begin
					cur_sz_q <= cur_sz_q + s_sz;
				end else begin
					m_q       <= m_q + NW'(1);
					cur_off_q <= s_off;
					cur_sz_q  <= s_sz;
				end
				cur_end_q <= s_end;
				i_q       <= i1;
			end
			S_F_MLST: begin
				m_q <= m_q + NW'(1);
				i_q <= '0;
				if ((NW+1)'(m_q) + (NW+1)'(1) > FREE_N) begin
					st_q <= ST_FULL;
				end
			end
			S_F_BWR: i_q <= i1;
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire
